FILE: src/csma_pkg.sv
// shared types and constants of the csma backoff controller
package csma_pkg;

    localparam int RND_W     = 32;
    localparam int DIVISOR_W = 17;
    localparam int SLOT_W    = 15;
    localparam int UNIT_W    = 8;
    localparam int WAIT_W    = 23;
    localparam int WIN_W     = 16;
    localparam int EXP_W     = 5;
    localparam int MAXEXP_W  = 4;
    localparam int PROB_W    = 17;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_INIT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_MAX  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BE_MAX   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BE_UNIT  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFER    = 8'd7;

    localparam logic [1:0] SCH_BINARY = 2'd0;
    localparam logic [1:0] SCH_EXPO   = 2'd1;
    localparam logic [1:0] SCH_LEGACY = 2'd2;

    localparam logic [EXP_W-1:0] EXP_START = 5'd2;

    typedef enum logic [1:0] {
        CMD_NEW    = 2'd0,
        CMD_ASSESS = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_IRQ    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_BACKOFF  = 3'd1,
        ACT_DEFER    = 3'd2,
        ACT_TRANSMIT = 3'd3,
        ACT_DROP     = 3'd4,
        ACT_TXDONE   = 3'd5,
        ACT_RXEVENT  = 3'd6,
        ACT_HOLD     = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_MUL  = 2'd2,
        ST_PUT  = 2'd3
    } t_state;

endpackage

FILE: src/csma_divser.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module csma_divser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [csma_pkg::RND_W-1:0]          i_dividend,
    input  logic [csma_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                o_done,
    output logic [csma_pkg::DIVISOR_W-1:0]      o_rem
);
    localparam int CNT_W = $clog2(csma_pkg::RND_W);
    localparam int DW    = csma_pkg::DIVISOR_W;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [csma_pkg::RND_W-1:0] r_num, n_num;
    logic [DW-1:0]     r_den, n_den;
    logic [DW-1:0]     r_rem, n_rem;
    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[csma_pkg::RND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_dividend;
            n_den  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_num = {r_num[csma_pkg::RND_W-2:0], 1'b0};
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(csma_pkg::RND_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: src/csma_mulser.sv
// shift-add slot multiplier, one multiplier bit per cycle
module csma_mulser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [csma_pkg::SLOT_W-1:0]      i_slot,
    input  logic [csma_pkg::UNIT_W-1:0]      i_unit,
    output logic                             o_done,
    output logic [csma_pkg::WAIT_W-1:0]      o_prod
);
    localparam int CNT_W = $clog2(csma_pkg::UNIT_W);
    localparam int PW    = csma_pkg::WAIT_W;

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [PW-1:0]                r_mcand, n_mcand;
    logic [csma_pkg::UNIT_W-1:0]  r_mplier, n_mplier;
    logic [PW-1:0]                r_acc, n_acc;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        if (i_start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_mcand  = PW'(i_slot);
            n_mplier = i_unit;
            n_acc    = '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = {r_mcand[PW-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[csma_pkg::UNIT_W-1:1]};
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(csma_pkg::UNIT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: src/csma_backoff_controller_core.sv
// random-backoff medium-access controller with serial draw units
// a request passes into the result state and then the output register; binary or
// legacy backoff first runs the serial remainder unit, exponent backoff the slot multiplier
// one request at a time; the next is taken while the result waits at the output
// the result state holds its result until the output is free
// synchronous active-low reset restores register defaults and clears the control state
module csma_backoff_controller_core #(
    parameter int LEGACY_MIN_MS = 5,
    parameter int LEGACY_MAX_MS = 50,
    parameter int GUARD_MS      = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] channel_free, [32:1] random_word, [33] start_ok, [39:34] zero
    input  logic [39:0]                         s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [22:0] wait_ms, [23] transmitting
    output logic [23:0]                         m_axis_tdata,
    // [2:0] action
    output logic [2:0]                          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [csma_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [csma_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    localparam int WW  = csma_pkg::WAIT_W;
    localparam int DW  = csma_pkg::DIVISOR_W;
    localparam int LEG_SPAN = LEGACY_MAX_MS - LEGACY_MIN_MS + 1;
    localparam logic LEG_OK = (LEGACY_MAX_MS >= LEGACY_MIN_MS);

    logic [1:0]                     r_scheme;
    logic [csma_pkg::WIN_W-1:0]     r_bin_init, r_bin_max, r_defer;
    logic [csma_pkg::MAXEXP_W-1:0]  r_be_max;
    logic [csma_pkg::UNIT_W-1:0]    r_be_unit;
    logic                           r_persist;
    logic [csma_pkg::PROB_W-1:0]    r_prob;

    csma_pkg::t_state               r_state, n_state;
    logic                           r_pending, n_pending;
    logic                           r_tx, n_tx;
    logic [csma_pkg::WIN_W-1:0]     r_win, n_win;
    logic [csma_pkg::EXP_W-1:0]     r_exp, n_exp;
    logic                           r_legacy, n_legacy;
    csma_pkg::t_action              r_res_act, n_res_act;
    logic [WW-1:0]                  r_res_wait, n_res_wait;
    logic                           r_ovalid, n_ovalid;
    csma_pkg::t_action              r_oact, n_oact;
    logic [WW-1:0]                  r_owait, n_owait;
    logic                           r_otx, n_otx;

    logic                           w_div_start, w_div_done;
    logic                           w_mul_start, w_mul_done;
    logic [DW-1:0]                  w_divisor;
    logic [DW-1:0]                  w_rem;
    logic [WW-1:0]                  w_prod;
    logic [csma_pkg::SLOT_W-1:0]    w_slot;
    logic [csma_pkg::EXP_W-1:0]     w_exp_cl;
    logic [csma_pkg::SLOT_W:0]      w_mask;
    logic [csma_pkg::WIN_W:0]       w_doubled;
    logic                           w_acc;
    csma_pkg::t_cmd                 w_cmd;
    logic                           w_free, w_ok;
    logic [csma_pkg::RND_W-1:0]     w_rnd;
    logic                           w_defer;

    assign w_cmd  = csma_pkg::t_cmd'(s_axis_tuser);
    assign w_free = s_axis_tdata[0];
    assign w_rnd  = s_axis_tdata[32:1];
    assign w_ok   = s_axis_tdata[33];
    assign s_axis_tready = (r_state == csma_pkg::ST_IDLE);
    assign w_acc  = s_axis_tvalid && s_axis_tready;

    assign w_exp_cl  = (r_exp > {1'b0, r_be_max}) ? {1'b0, r_be_max} : r_exp;
    assign w_mask    = ({{csma_pkg::SLOT_W{1'b0}}, 1'b1} << w_exp_cl[3:0]) - 1'b1;
    assign w_slot    = w_rnd[csma_pkg::SLOT_W-1:0] & w_mask[csma_pkg::SLOT_W-1:0];
    assign w_doubled = {r_win, 1'b0};
    assign w_defer   = r_persist && ({1'b0, w_rnd} > {r_prob, 16'd0});

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme   <= csma_pkg::SCH_LEGACY;
            r_bin_init <= 16'd10;
            r_bin_max  <= 16'd1000;
            r_be_max   <= 4'd5;
            r_be_unit  <= 8'd10;
            r_persist  <= 1'b0;
            r_prob     <= 17'd65536;
            r_defer    <= 16'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csma_pkg::CFG_SCHEME:   r_scheme   <= i_cfg_data[1:0];
                csma_pkg::CFG_BIN_INIT: r_bin_init <= i_cfg_data[15:0];
                csma_pkg::CFG_BIN_MAX:  r_bin_max  <= i_cfg_data[15:0];
                csma_pkg::CFG_BE_MAX:   r_be_max   <= i_cfg_data[3:0];
                csma_pkg::CFG_BE_UNIT:  r_be_unit  <= i_cfg_data[7:0];
                csma_pkg::CFG_PERSIST:  r_persist  <= i_cfg_data[0];
                csma_pkg::CFG_PROB:     r_prob     <= i_cfg_data;
                csma_pkg::CFG_DEFER:    r_defer    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_tx       = r_tx;
        n_win      = r_win;
        n_exp      = r_exp;
        n_legacy   = r_legacy;
        n_res_act  = r_res_act;
        n_res_wait = r_res_wait;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_oact     = r_oact;
        n_owait    = r_owait;
        n_otx      = r_otx;
        w_div_start = 1'b0;
        w_mul_start = 1'b0;
        w_divisor   = DW'(LEG_SPAN);
        unique case (r_state)
            csma_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_res_act  = csma_pkg::ACT_NONE;
                    n_res_wait = '0;
                    n_state    = csma_pkg::ST_PUT;
                    unique case (w_cmd)
                        csma_pkg::CMD_NEW: begin
                            n_pending = 1'b1;
                            n_win     = r_bin_init;
                            n_exp     = csma_pkg::EXP_START;
                        end
                        csma_pkg::CMD_ASSESS: begin
                            priority if (!r_pending) begin
                                n_res_act = csma_pkg::ACT_NONE;
                            end else if (r_tx) begin
                                n_res_act = csma_pkg::ACT_HOLD;
                            end else if (!w_free) begin
                                n_res_act = csma_pkg::ACT_BACKOFF;
                                unique case (r_scheme)
                                    csma_pkg::SCH_BINARY: begin
                                        w_divisor   = {1'b0, r_win} + 1'b1;
                                        w_div_start = 1'b1;
                                        n_legacy    = 1'b0;
                                        n_win = (w_doubled < {1'b0, r_bin_max}) ?
                                                w_doubled[csma_pkg::WIN_W-1:0] : r_bin_max;
                                        n_state = csma_pkg::ST_DIV;
                                    end
                                    csma_pkg::SCH_EXPO: begin
                                        w_mul_start = 1'b1;
                                        n_exp   = w_exp_cl + 1'b1;
                                        n_state = csma_pkg::ST_MUL;
                                    end
                                    default: begin
                                        if (LEG_OK) begin
                                            w_div_start = 1'b1;
                                            n_legacy    = 1'b1;
                                            n_state     = csma_pkg::ST_DIV;
                                        end else begin
                                            n_res_wait = WW'(LEGACY_MIN_MS);
                                        end
                                    end
                                endcase
                            end else if (w_defer) begin
                                n_res_act  = csma_pkg::ACT_DEFER;
                                n_res_wait = WW'(r_defer);
                            end else begin
                                n_res_act  = csma_pkg::ACT_TRANSMIT;
                                n_res_wait = WW'(GUARD_MS);
                                n_tx       = 1'b1;
                                n_pending  = 1'b0;
                            end
                        end
                        csma_pkg::CMD_STATUS: begin
                            if (r_tx && !w_ok) begin
                                n_tx      = 1'b0;
                                n_res_act = csma_pkg::ACT_DROP;
                            end
                        end
                        default: begin
                            if (r_tx) begin
                                n_tx      = 1'b0;
                                n_res_act = csma_pkg::ACT_TXDONE;
                            end else begin
                                n_res_act = csma_pkg::ACT_RXEVENT;
                            end
                        end
                    endcase
                end
            end
            csma_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_res_wait = r_legacy ? (WW'(LEGACY_MIN_MS) + WW'(w_rem)) : WW'(w_rem);
                    n_state    = csma_pkg::ST_PUT;
                end
            end
            csma_pkg::ST_MUL: begin
                if (w_mul_done) begin
                    n_res_wait = w_prod;
                    n_state    = csma_pkg::ST_PUT;
                end
            end
            default: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oact   = r_res_act;
                    n_owait  = r_res_wait;
                    n_otx    = r_tx;
                    n_state  = csma_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= csma_pkg::ST_IDLE;
            r_pending <= 1'b0;
            r_tx      <= 1'b0;
            r_win     <= '0;
            r_exp     <= csma_pkg::EXP_START;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_tx      <= n_tx;
            r_win     <= n_win;
            r_exp     <= n_exp;
            r_ovalid  <= n_ovalid;
        end
        r_legacy   <= n_legacy;
        r_res_act  <= n_res_act;
        r_res_wait <= n_res_wait;
        r_oact     <= n_oact;
        r_owait    <= n_owait;
        r_otx      <= n_otx;
    end

    csma_divser u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_rnd),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    csma_mulser u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_slot  (w_slot),
        .i_unit  (r_be_unit),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_otx, r_owait};
    assign m_axis_tuser  = r_oact;

`ifndef SYNTH
    a_quick_cmd_to_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd != csma_pkg::CMD_ASSESS) |=> (r_state == csma_pkg::ST_PUT))
        else $error("non-assessment request did not go straight to result");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == csma_pkg::ST_DIV))
        else $error("remainder unit finished outside its state");

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == csma_pkg::ST_MUL))
        else $error("slot multiplier finished outside its state");

    a_wait_only_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_owait != '0) |-> (r_oact == csma_pkg::ACT_BACKOFF ||
        r_oact == csma_pkg::ACT_DEFER || r_oact == csma_pkg::ACT_TRANSMIT))
        else $error("nonzero wait on an action without a wait");

    a_hold_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oact == csma_pkg::ACT_HOLD) |-> r_otx)
        else $error("hold reported with no transmission in flight");
`endif

endmodule
